FILE: rtl/cal_pkg.sv
// ----------------------------------------------------------------------------
// cal_pkg
// Command codes and controller states shared by the compacting list design.
// ----------------------------------------------------------------------------
package cal_pkg;

    typedef enum logic [2:0] {
        CMD_APPEND     = 3'd0,
        CMD_REMOVE_VAL = 3'd1,
        CMD_REMOVE_IDX = 3'd2,
        CMD_READ       = 3'd3,
        CMD_WRITE      = 3'd4,
        CMD_CLEAR      = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_SHIFT,
        ST_CLEAR,
        ST_EMIT
    } t_state;

    localparam int unsigned INDEX_W = 5;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 6;

endpackage

FILE: rtl/cal_store.sv
// ----------------------------------------------------------------------------
// cal_store
// Item storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cal_store #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5,
    parameter int unsigned DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/compacting_array_list.sv
// ----------------------------------------------------------------------------
// compacting_array_list
// Bounded ordered list with append, remove by value, remove at index, read,
// write and clear. Removal compacts the store so order is kept.
// ----------------------------------------------------------------------------
// Append, write, clear without reporting and failed commands: status in the
// cycle after start with busy low, so one item per cycle. Read: the store
// registers the item, then the result register. Remove by value and reporting
// clear walk the store, one entry per cycle, then one result per reported
// match. Remove at index walks the tail only. Results cannot be stalled.
// Synchronous reset empties the list, idles control, clears the report bit.
// ----------------------------------------------------------------------------
module compacting_array_list
    import cal_pkg::*;
#(
    parameter int unsigned CAPACITY   = 32,
    parameter int unsigned ITEM_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_command,
    input  logic [INDEX_W-1:0] i_index,
    input  logic [DATA_W-1:0]  i_item_value,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    output logic               o_valid,
    output logic               o_kind,
    output logic [DATA_W-1:0]  o_data,
    output logic [COUNT_W-1:0] o_entry_count,
    output logic               o_error,
    output logic               o_last
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned XW = (CW > INDEX_W) ? CW : INDEX_W;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_report;
    logic [CW-1:0]         r_ptr, n_ptr;
    logic [CW-1:0]         r_wp, n_wp;
    logic [CW-1:0]         r_match, n_match;
    logic                  r_rv, n_rv;
    logic                  r_first, n_first;
    logic [ITEM_WIDTH-1:0] r_val, n_val;

    logic                  r_o_valid, n_o_valid;
    logic                  r_o_kind, n_o_kind;
    logic [DATA_W-1:0]     r_o_data, n_o_data;
    logic [COUNT_W-1:0]    r_o_cnt, n_o_cnt;
    logic                  r_o_err, n_o_err;
    logic                  r_o_last, n_o_last;

    logic                  mem_wr_en;
    logic [AW-1:0]         mem_wr_addr;
    logic [ITEM_WIDTH-1:0] mem_wr_data;
    logic                  mem_rd_en;
    logic [AW-1:0]         mem_rd_addr;
    logic [ITEM_WIDTH-1:0] mem_rd_data;

    logic                  accept;
    logic [ITEM_WIDTH-1:0] in_val;
    logic                  in_range;
    logic                  full;
    logic                  issue;
    logic                  walk_done;
    t_cmd                  cmd;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign cmd      = t_cmd'(i_command);
    assign in_val   = ITEM_WIDTH'(i_item_value);
    assign in_range = XW'(i_index) < XW'(r_count);
    assign full     = (r_count == CW'(CAPACITY));
    assign issue    = (r_ptr < r_count);
    assign walk_done = r_rv && !issue;

    cal_store #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (ITEM_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_wp      = r_wp;
        n_match   = r_match;
        n_rv      = 1'b0;
        n_first   = r_first;
        n_val     = r_val;
        n_o_valid = 1'b0;
        n_o_kind  = 1'b0;
        n_o_data  = '0;
        n_o_cnt   = COUNT_W'(r_count);
        n_o_err   = 1'b0;
        n_o_last  = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_wp[AW-1:0];
        mem_wr_data = mem_rd_data;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_ptr[AW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_val     = in_val;
                    n_o_valid = 1'b1;
                    n_o_last  = 1'b1;
                    case (cmd)
                        CMD_APPEND: begin
                            if (full) begin
                                n_o_err = 1'b1;
                            end else begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = AW'(r_count);
                                mem_wr_data = in_val;
                                n_count     = r_count + 1'b1;
                                n_o_cnt     = COUNT_W'(n_count);
                            end
                        end
                        CMD_REMOVE_VAL: begin
                            if (r_count != '0) begin
                                n_o_valid   = 1'b0;
                                n_o_last    = 1'b0;
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = '0;
                                n_ptr       = CW'(1);
                                n_wp        = '0;
                                n_match     = '0;
                                n_rv        = 1'b1;
                                n_state     = ST_SCAN;
                            end
                        end
                        CMD_REMOVE_IDX: begin
                            if (!in_range) begin
                                n_o_err = 1'b1;
                            end else begin
                                n_o_valid   = 1'b0;
                                n_o_last    = 1'b0;
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = AW'(i_index);
                                n_ptr       = CW'(i_index) + 1'b1;
                                n_wp        = CW'(i_index);
                                n_first     = 1'b1;
                                n_rv        = 1'b1;
                                n_state     = ST_SHIFT;
                            end
                        end
                        CMD_READ: begin
                            if (!in_range) begin
                                n_o_err = 1'b1;
                            end else begin
                                n_o_valid   = 1'b0;
                                n_o_last    = 1'b0;
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = AW'(i_index);
                                n_state     = ST_READ;
                            end
                        end
                        CMD_WRITE: begin
                            if (!in_range) begin
                                n_o_err = 1'b1;
                            end else begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = AW'(i_index);
                                mem_wr_data = in_val;
                            end
                        end
                        CMD_CLEAR: begin
                            if (r_report && (r_count != '0)) begin
                                n_o_valid   = 1'b0;
                                n_o_last    = 1'b0;
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = '0;
                                n_ptr       = CW'(1);
                                n_rv        = 1'b1;
                                n_state     = ST_CLEAR;
                            end else begin
                                n_count = '0;
                                n_o_cnt = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_o_valid = 1'b1;
                n_o_last  = 1'b1;
                n_o_data  = DATA_W'(mem_rd_data);
                n_state   = ST_IDLE;
            end
            ST_SCAN: begin
                if (issue) begin
                    mem_rd_en = 1'b1;
                    n_ptr     = r_ptr + 1'b1;
                    n_rv      = 1'b1;
                end
                if (r_rv) begin
                    if (mem_rd_data == r_val) begin
                        n_match = r_match + 1'b1;
                    end else begin
                        mem_wr_en = 1'b1;
                        n_wp      = r_wp + 1'b1;
                    end
                end
                if (walk_done) begin
                    n_count = n_wp;
                    if (!r_report) begin
                        n_match = '0;
                    end
                    n_state = ST_EMIT;
                end
            end
            ST_SHIFT: begin
                if (issue) begin
                    mem_rd_en = 1'b1;
                    n_ptr     = r_ptr + 1'b1;
                    n_rv      = 1'b1;
                end
                if (r_rv) begin
                    if (r_first) begin
                        n_first   = 1'b0;
                        n_o_valid = r_report;
                        n_o_kind  = 1'b1;
                        n_o_data  = DATA_W'(mem_rd_data);
                        n_o_cnt   = COUNT_W'(r_count - 1'b1);
                    end else begin
                        mem_wr_en = 1'b1;
                        n_wp      = r_wp + 1'b1;
                    end
                end
                if (walk_done) begin
                    n_count = r_count - 1'b1;
                    n_match = '0;
                    n_state = ST_EMIT;
                end
            end
            ST_CLEAR: begin
                if (issue) begin
                    mem_rd_en = 1'b1;
                    n_ptr     = r_ptr + 1'b1;
                    n_rv      = 1'b1;
                end
                if (r_rv) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = 1'b1;
                    n_o_data  = DATA_W'(mem_rd_data);
                    n_o_cnt   = '0;
                end
                if (walk_done) begin
                    n_count = '0;
                    n_match = '0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                n_o_valid = 1'b1;
                if (r_match != '0) begin
                    // every match equals the search value
                    n_o_kind = 1'b1;
                    n_o_data = DATA_W'(r_val);
                    n_match  = r_match - 1'b1;
                end else begin
                    n_o_last = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_report  <= 1'b0;
            r_rv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rv      <= n_rv;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                r_report <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_wp     <= n_wp;
        r_match  <= n_match;
        r_first  <= n_first;
        r_val    <= n_val;
        r_o_kind <= n_o_kind;
        r_o_data <= n_o_data;
        r_o_cnt  <= n_o_cnt;
        r_o_err  <= n_o_err;
        r_o_last <= n_o_last;
    end

    assign o_valid       = r_o_valid;
    assign o_kind        = r_o_kind;
    assign o_data        = r_o_data;
    assign o_entry_count = r_o_cnt;
    assign o_error       = r_o_err;
    assign o_last        = r_o_last;

endmodule

FILE: rtl/cal_checker.sv
// ----------------------------------------------------------------------------
// cal_checker
// Port-level checks for the compacting list, bound to the top level.
// ----------------------------------------------------------------------------
module cal_checker
    import cal_pkg::*;
#(
    parameter int unsigned CAPACITY = 32
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic               o_kind,
    input logic               o_error,
    input logic               o_last,
    input logic [COUNT_W-1:0] o_entry_count
);

    a_start_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ((o_valid && o_last) || busy))
        else $error("accepted item neither answered nor in progress");

    a_busy_ends_with_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_valid && o_last && !o_kind))
        else $error("busy dropped without a status result");

    a_report_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind) |-> (!o_last && !o_error && busy))
        else $error("report result malformed");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_kind) |-> o_last)
        else $error("status result without last");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entry_count <= COUNT_W'(CAPACITY)))
        else $error("entry count beyond capacity");

endmodule

bind compacting_array_list cal_checker #(.CAPACITY(CAPACITY)) u_cal_checker (.*);
